// ===== hw/rtl/gfdv_pkg.sv =====
`default_nettype none

package gfdv_pkg;

  localparam int TIME_W     = 48;
  localparam int POS_W      = 32;
  localparam int DIFF_W     = POS_W + 1;
  localparam int VEL_W      = 32;
  localparam int POS_THR_W  = 20;
  localparam int TIME_THR_W = 24;
  localparam int SCALE_W    = 20;
  localparam int NUM_W      = 52;
  localparam int QUO_W      = 32;
  localparam int CNT_W      = 5;
  localparam int MAX_AXES   = 3;
  localparam int IN_DATA_W  = TIME_W + MAX_AXES * POS_W;
  localparam int OUT_DATA_W = MAX_AXES * VEL_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 24;

  // microseconds per second
  localparam logic [SCALE_W-1:0]    SCALE        = 20'd1000000;
  localparam logic [POS_THR_W-1:0]  POS_THR_RST  = 20'd1;
  localparam logic [TIME_THR_W-1:0] TIME_THR_RST = 24'd100000;
  localparam logic [VEL_W-1:0]      VEL_MAX      = 32'h7fff_ffff;
  localparam logic [VEL_W-1:0]      VEL_MIN      = 32'h8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_THR  = 1'b0,
    REG_TIME_THR = 1'b1
  } cfg_reg_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_ABS  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_OVF  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_SAT  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gated_finite_difference_velocity.sv =====
`default_nettype none

// Velocity estimator for timestamped position samples, one result item per input item.
// The first sample after reset gives zero velocity; a sample whose time does not advance
// returns the held velocity untouched. An advancing sample recomputes velocity when any
// axis moved by more than the movement threshold (register 0, micrometres) or the refresh
// interval (register 1, microseconds) has passed since the last update:
// (pos - previous) * 1e6 / elapsed, truncated and saturated.
// A recomputed item passes the states PREP, ABS, MUL, OVF, DIV, SAT and FIN; DIV is a
// restoring divider that produces one quotient bit per cycle (32 steps, one lane per axis,
// all lanes in parallel). A held item goes from MUL to FIN, a first or stale item from PREP
// to FIN. One item is in flight at a time; the output register lets the next item in while
// a result waits. A result still waiting in the output register when the next one is done
// holds the block until the receiver takes it.
module gated_finite_difference_velocity #(
  parameter int AXES = 3
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // sample_time [47:0], pos_x [79:48], pos_y [111:80], pos_z [143:112]
  input  wire logic [gfdv_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                              in_tvalid,
  output      logic                              in_tready,
  // vel_x [31:0], vel_y [63:32], vel_z [95:64]
  output      logic [gfdv_pkg::OUT_DATA_W-1:0]   out_tdata,
  // recomputed [0]
  output      logic                              out_tuser,
  output      logic                              out_tvalid,
  input  wire logic                              out_tready,
  input  wire logic                              cfg_valid,
  output      logic                              cfg_ready,
  input  wire logic [gfdv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gfdv_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import gfdv_pkg::*;

  state_t                  state_r;
  logic [POS_THR_W-1:0]    pos_thr_r;
  logic [TIME_THR_W-1:0]   time_thr_r;
  logic                    have_prev_r;
  logic [TIME_W-1:0]       last_samp_r;
  logic [TIME_W-1:0]       last_vel_r;
  logic [TIME_W-1:0]       t_r;
  logic [TIME_W-1:0]       dt_r;
  logic                    rec_r;
  logic [CNT_W-1:0]        cnt_r;

  logic [POS_W-1:0]        pos_r     [AXES];
  logic [POS_W-1:0]        prev_r    [AXES];
  logic [VEL_W-1:0]        held_r    [AXES];
  logic [DIFF_W-1:0]       d_r       [AXES];
  logic [DIFF_W-1:0]       mag_r     [AXES];
  logic                    neg_r     [AXES];
  logic [NUM_W-1:0]        num_r     [AXES];
  logic                    ovf_r     [AXES];
  logic [TIME_W-1:0]       rem_r     [AXES];
  logic [QUO_W-1:0]        lo_r      [AXES];
  logic [VEL_W-1:0]        out_vel_r [AXES];
  logic                    out_rec_r;
  logic                    out_tvalid_r;

  logic [DIFF_W-1:0]       diff      [AXES];
  logic [TIME_W+1:0]       trial     [AXES];
  logic                    moved;
  logic                    upd;

  always_comb begin
    moved = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      diff[i]  = {pos_r[i][POS_W-1], pos_r[i]} - {prev_r[i][POS_W-1], prev_r[i]};
      // shift the next dividend bit into the partial remainder and try the subtract
      trial[i] = {1'b0, rem_r[i], lo_r[i][QUO_W-1]} - {2'b00, dt_r};
      if (mag_r[i] > {{(DIFF_W-POS_THR_W){1'b0}}, pos_thr_r})
        moved = 1'b1;
    end
    upd = moved || (dt_r >= {{(TIME_W-TIME_THR_W){1'b0}}, time_thr_r});
  end

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_rec_r;

  for (genvar g = 0; g < MAX_AXES; g++) begin : g_out
    if (g < AXES) begin : g_used
      assign out_tdata[g*VEL_W +: VEL_W] = out_vel_r[g];
    end else begin : g_unused
      assign out_tdata[g*VEL_W +: VEL_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_thr_r  <= POS_THR_RST;
      time_thr_r <= TIME_THR_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POS_THR:  pos_thr_r  <= cfg_data[POS_THR_W-1:0];
        REG_TIME_THR: time_thr_r <= cfg_data[TIME_THR_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_prev_r  <= 1'b0;
      last_samp_r  <= '0;
      last_vel_r   <= '0;
      rec_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
      out_rec_r    <= 1'b0;
      cnt_r        <= '0;
      for (int i = 0; i < AXES; i++) begin
        prev_r[i] <= '0;
        held_r[i] <= '0;
      end
    end else begin
      // in the final state the output register is reloaded whenever it is taken
      if (out_tvalid_r && out_tready && (state_r != S_FIN))
        out_tvalid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            t_r <= in_tdata[TIME_W-1:0];
            for (int i = 0; i < AXES; i++)
              pos_r[i] <= in_tdata[TIME_W + i*POS_W +: POS_W];
            state_r <= S_PREP;
          end
        end

        S_PREP: begin
          dt_r <= t_r - last_vel_r;
          for (int i = 0; i < AXES; i++)
            d_r[i] <= diff[i];
          if (!have_prev_r) begin
            for (int i = 0; i < AXES; i++) begin
              held_r[i] <= '0;
              prev_r[i] <= pos_r[i];
            end
            last_samp_r <= t_r;
            last_vel_r  <= t_r;
            have_prev_r <= 1'b1;
            rec_r       <= 1'b1;
            state_r     <= S_FIN;
          end else if (t_r > last_samp_r) begin
            state_r <= S_ABS;
          end else begin
            // stale timestamp: nothing changes
            rec_r   <= 1'b0;
            state_r <= S_FIN;
          end
        end

        S_ABS: begin
          for (int i = 0; i < AXES; i++) begin
            neg_r[i] <= d_r[i][DIFF_W-1];
            mag_r[i] <= d_r[i][DIFF_W-1] ? (DIFF_W'(0) - d_r[i]) : d_r[i];
          end
          state_r <= S_MUL;
        end

        S_MUL: begin
          for (int i = 0; i < AXES; i++)
            num_r[i] <= {{(NUM_W-DIFF_W){1'b0}}, mag_r[i]}
                        * {{(NUM_W-SCALE_W){1'b0}}, SCALE};
          if (upd) begin
            state_r <= S_OVF;
          end else begin
            for (int i = 0; i < AXES; i++)
              prev_r[i] <= pos_r[i];
            last_samp_r <= t_r;
            rec_r       <= 1'b0;
            state_r     <= S_FIN;
          end
        end

        S_OVF: begin
          // upper part of the dividend at or above dt means a quotient of 2^32 or more
          for (int i = 0; i < AXES; i++) begin
            ovf_r[i] <= {{(TIME_W-(NUM_W-QUO_W)){1'b0}}, num_r[i][NUM_W-1:QUO_W]} >= dt_r;
            rem_r[i] <= {{(TIME_W-(NUM_W-QUO_W)){1'b0}}, num_r[i][NUM_W-1:QUO_W]};
            lo_r[i]  <= num_r[i][QUO_W-1:0];
          end
          cnt_r   <= '0;
          state_r <= S_DIV;
        end

        S_DIV: begin
          for (int i = 0; i < AXES; i++) begin
            if (!trial[i][TIME_W+1]) begin
              rem_r[i] <= trial[i][TIME_W-1:0];
              lo_r[i]  <= {lo_r[i][QUO_W-2:0], 1'b1};
            end else begin
              rem_r[i] <= {rem_r[i][TIME_W-2:0], lo_r[i][QUO_W-1]};
              lo_r[i]  <= {lo_r[i][QUO_W-2:0], 1'b0};
            end
          end
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == CNT_W'(QUO_W-1))
            state_r <= S_SAT;
        end

        S_SAT: begin
          for (int i = 0; i < AXES; i++) begin
            if (neg_r[i]) begin
              if (ovf_r[i] || (lo_r[i] > VEL_MIN))
                held_r[i] <= VEL_MIN;
              else
                held_r[i] <= VEL_W'(0) - lo_r[i];
            end else begin
              if (ovf_r[i] || lo_r[i][QUO_W-1])
                held_r[i] <= VEL_MAX;
              else
                held_r[i] <= lo_r[i];
            end
            prev_r[i] <= pos_r[i];
          end
          last_samp_r <= t_r;
          last_vel_r  <= t_r;
          rec_r       <= 1'b1;
          state_r     <= S_FIN;
        end

        S_FIN: begin
          if (!out_tvalid_r || out_tready) begin
            for (int i = 0; i < AXES; i++)
              out_vel_r[i] <= held_r[i];
            out_rec_r    <= rec_r;
            out_tvalid_r <= 1'b1;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_gated_finite_difference_velocity.sv =====
`timescale 1ns / 100ps

module tb_gated_finite_difference_velocity;
  import gfdv_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam longint unsigned US_PER_S = 64'd1000000;

  typedef struct packed {
    logic [MAX_AXES-1:0][POS_W-1:0] pos;
    logic [TIME_W-1:0]              stamp;
  } sample_t;

  typedef struct packed {
    logic [MAX_AXES-1:0][VEL_W-1:0] vel;
    logic                           recomputed;
  } velocity_t;

  logic                  clk         = 1'b0;
  logic                  rst_n       = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata    = '0;
  logic                  in_tvalid   = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready  = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;

  gated_finite_difference_velocity u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // estimator state as the block should hold it
  logic [POS_THR_W-1:0]           cur_pos_thr  = POS_THR_RST;
  logic [TIME_THR_W-1:0]          cur_time_thr = TIME_THR_RST;
  logic                           st_have_prev = 1'b0;
  logic [TIME_W-1:0]              st_last_time = '0;
  logic [TIME_W-1:0]              st_vel_time  = '0;
  logic [MAX_AXES-1:0][POS_W-1:0] st_prev_pos  = '0;
  logic [MAX_AXES-1:0][VEL_W-1:0] st_held_vel  = '0;

  velocity_t velocity_due_q[$];
  int        errors = 0;

  // stimulus side
  int                             send_idle_pct = 0;
  int                             stall_pct     = 0;
  logic                           hold_req      = 1'b0;
  int                             hold_count    = 0;
  logic                           drv_started   = 1'b0;
  logic [TIME_W-1:0]              drv_time      = '0;
  logic [MAX_AXES-1:0][POS_W-1:0] drv_pos       = '0;

  function automatic logic [VEL_W-1:0] rate_um_per_s(input longint signed delta,
                                                     input longint unsigned dt);
    longint unsigned mag;
    longint unsigned q;
    logic [63:0]     neg_q;
    mag = (delta < 0) ? -delta : delta;
    mag = mag * US_PER_S;
    q = (dt == 0) ? 64'd0 : mag / dt;
    if (delta < 0) begin
      if (q > 64'd2147483648) return VEL_MIN;
      neg_q = -q;
      return neg_q[VEL_W-1:0];
    end
    if (q > 64'd2147483647) return VEL_MAX;
    return q[VEL_W-1:0];
  endfunction

  function automatic velocity_t predict_velocity(input sample_t s);
    velocity_t       r;
    longint unsigned dt;
    longint signed   d [MAX_AXES];
    longint unsigned ad;
    logic            refresh;
    int              a;
    r = '0;
    if (!st_have_prev) begin
      st_held_vel  = '0;
      st_prev_pos  = s.pos;
      st_last_time = s.stamp;
      st_vel_time  = s.stamp;
      st_have_prev = 1'b1;
      r.recomputed = 1'b1;
    end else if (s.stamp > st_last_time) begin
      dt = 64'(s.stamp - st_vel_time);
      refresh = (dt >= longint'(cur_time_thr));
      for (a = 0; a < MAX_AXES; a++) begin
        d[a] = longint'($signed(s.pos[a])) - longint'($signed(st_prev_pos[a]));
        ad = (d[a] < 0) ? -d[a] : d[a];
        if (ad > longint'(cur_pos_thr)) refresh = 1'b1;
      end
      if (refresh) begin
        for (a = 0; a < MAX_AXES; a++) st_held_vel[a] = rate_um_per_s(d[a], dt);
        st_vel_time  = s.stamp;
        r.recomputed = 1'b1;
      end
      st_prev_pos  = s.pos;
      st_last_time = s.stamp;
    end
    r.vel = st_held_vel;
    return r;
  endfunction

  // register writes and accepted items feed the predictor
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_POS_THR:  cur_pos_thr  = cfg_data[POS_THR_W-1:0];
          REG_TIME_THR: cur_time_thr = cfg_data[TIME_THR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) velocity_due_q.push_back(predict_velocity(sample_t'(in_tdata)));
    end
  end

  task automatic report_mismatch(input string what, input int axis,
                                 input logic [31:0] got, input logic [31:0] want);
    $display("%0t ns: mismatch on %s (axis %0d): got %h, want %h", $time, what, axis, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    velocity_t want;
    int        a;
    if (rst_n && out_tvalid && out_tready) begin
      if (velocity_due_q.size() == 0) begin
        report_mismatch("item with nothing pending", -1, out_tdata[VEL_W-1:0], '0);
      end else begin
        want = velocity_due_q.pop_front();
        for (a = 0; a < MAX_AXES; a++)
          if (out_tdata[a*VEL_W +: VEL_W] !== want.vel[a])
            report_mismatch("velocity", a, out_tdata[a*VEL_W +: VEL_W], want.vel[a]);
        if (out_tuser !== want.recomputed)
          report_mismatch("recomputed flag", -1, {31'd0, out_tuser}, {31'd0, want.recomputed});
      end
    end
  end

  // receiver: random stalls, plus one long hold counted here
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_count <= 0;
    end else if (hold_req && hold_count < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_count <= hold_count + 1;
    end else begin
      if (!hold_req) hold_count <= 0;
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic set_idle(input int send_pct, input int rx_pct);
    send_idle_pct = send_pct;
    stall_pct <= rx_pct;
  endtask

  // leaves tvalid high after the handshake so back-to-back items have no bubble
  task automatic send_sample(input sample_t s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tdata  <= s;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (!drv_started || s.stamp > drv_time) begin
      drv_started = 1'b1;
      drv_time    = s.stamp;
      drv_pos     = s.pos;
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (velocity_due_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic sample_t fixed_sample(input logic [TIME_W-1:0] stamp, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] z);
    sample_t s;
    s.stamp  = stamp;
    s.pos[0] = x;
    s.pos[1] = y;
    s.pos[2] = z;
    return s;
  endfunction

  // mostly advancing samples near the previous position, some stale or wild ones
  function automatic sample_t random_sample();
    sample_t         s;
    longint unsigned adv;
    int              k;
    int              a;
    if ($urandom_range(99) < 8) begin
      s.stamp = (drv_time > 3) ? drv_time - $urandom_range(0, 3) : drv_time;
      for (a = 0; a < MAX_AXES; a++) s.pos[a] = $urandom();
      return s;
    end
    k = $urandom_range(99);
    if (k < 2)       adv = {$urandom(), $urandom()} & 64'hFF_FFFF_FFFF;
    else if (k < 10) adv = 64'($urandom());
    else if (k < 30) adv = 64'($urandom_range(1, 50));
    else             adv = 64'($urandom_range(1, 2 * cur_time_thr + 2));
    if (adv == 0) adv = 1;
    s.stamp = TIME_W'(drv_time + adv);
    for (a = 0; a < MAX_AXES; a++) begin
      k = $urandom_range(99);
      if (k < 30)      s.pos[a] = drv_pos[a];
      else if (k < 80) s.pos[a] = drv_pos[a] + $urandom_range(0, 2 * cur_pos_thr + 2)
                                  - cur_pos_thr - 1;
      else if (k < 95) s.pos[a] = drv_pos[a] + $urandom_range(0, 2 ** 21) - 2 ** 20;
      else             s.pos[a] = $urandom();
    end
    return s;
  endfunction

  task automatic test_first_sample();
    set_idle(0, 0);
    send_sample(fixed_sample(48'd0, 32'h7fff_ffff, 32'h8000_0000, 32'd0));
    // same time again is ignored
    send_sample(fixed_sample(48'd0, 32'd0, 32'd0, 32'd0));
    // full swing in one microsecond saturates both ways
    send_sample(fixed_sample(48'd1, 32'h8000_0000, 32'h7fff_ffff, 32'd12345));
    send_sample(fixed_sample(48'd2, 32'h8000_0000, 32'h7fff_ffff, 32'd12345));
    // movement equal to the threshold holds
    send_sample(fixed_sample(48'd3, 32'h8000_0001, 32'h7fff_ffff, 32'd12345));
    // elapsed time counts from the last update, not the last sample
    send_sample(fixed_sample(48'd5, 32'h8000_0003, 32'h7fff_ffff, 32'd12345));
    send_sample(fixed_sample(48'd100005, 32'h8000_0003, 32'h7fff_ffff, 32'd12345));
    send_sample(fixed_sample(48'd100004, 32'd77, 32'd88, 32'd99));
    send_sample(fixed_sample(48'd100010, 32'h7fff_fffc, 32'h7fff_fffc, 32'd13345));
    send_sample(fixed_sample(48'd100013, 32'h7fff_fffd, 32'h7fff_fff0, 32'd13344));
  endtask

  task automatic test_threshold_extremes();
    drain_results();
    write_reg(REG_POS_THR, 24'd0);
    write_reg(REG_TIME_THR, 24'd0);
    // zero time threshold: every advancing sample recomputes
    send_sample(fixed_sample(drv_time + 1, drv_pos[0], drv_pos[1], drv_pos[2]));
    send_sample(fixed_sample(drv_time + 3, drv_pos[0] + 1, drv_pos[1], drv_pos[2] - 1));
    drain_results();
    write_reg(REG_POS_THR, 24'd1000000);
    write_reg(REG_TIME_THR, 24'd10000000);
    send_sample(fixed_sample(drv_time + 7, drv_pos[0] + 1000000, drv_pos[1] - 1000000,
                             drv_pos[2]));
    send_sample(fixed_sample(drv_time + 9, drv_pos[0], drv_pos[1] - 1000001, drv_pos[2]));
    send_sample(fixed_sample(drv_time + 10000000, drv_pos[0], drv_pos[1], drv_pos[2]));
  endtask

  task automatic run_random_phase(input logic [POS_THR_W-1:0] pos_thr,
                                  input logic [TIME_THR_W-1:0] time_thr,
                                  input int send_pct, input int rx_pct, input int count);
    drain_results();
    write_reg(REG_POS_THR, 24'(pos_thr));
    write_reg(REG_TIME_THR, time_thr);
    set_idle(send_pct, rx_pct);
    repeat (count) send_sample(random_sample());
  endtask

  task automatic test_backpressure();
    drain_results();
    set_idle(0, 0);
    hold_req <= 1'b1;
    repeat (10) send_sample(random_sample());
    while (hold_count < HOLD_CYCLES) @(posedge clk);
    hold_req <= 1'b0;
  endtask

  task automatic test_time_extremes();
    drain_results();
    set_idle(0, 0);
    send_sample(fixed_sample(48'hffff_ffff_fffe, 32'h7fff_ffff, 32'h8000_0000, 32'h5555_aaaa));
    send_sample(fixed_sample(48'hffff_ffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'haaaa_5555));
    send_sample(fixed_sample(48'd0, 32'd1, 32'd2, 32'd3));
    send_sample(fixed_sample(48'hffff_ffff_ffff, 32'd4, 32'd5, 32'd6));
  endtask

  task automatic finish_run();
    drain_results();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_sample();
    test_threshold_extremes();
    run_random_phase(20'd1, 24'd100000, 0, 0, 300);
    run_random_phase(20'd0, 24'd0, 83, 0, 300);
    run_random_phase(20'd1000000, 24'd10000000, 0, 83, 300);
    run_random_phase(20'd50, 24'd2000, 23, 23, 300);
    test_backpressure();
    run_random_phase(20'hfffff, 24'hffffff, 0, 0, 200);
    run_random_phase(20'd1000, 24'd1, 23, 23, 250);
    test_time_extremes();
    finish_run();
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
